// ----- rtl/bucketed_edge_table_search_defines.svh -----
// Assertion macros shared by the RTL files.
`ifndef BUCKETED_EDGE_TABLE_SEARCH_DEFINES_SVH
`define BUCKETED_EDGE_TABLE_SEARCH_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define BETS_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) expr) else $error(msg);
// checked on every edge, reset included
`define BETS_ASSERT_ANY(label, expr, msg) \
    label: assert property (@(posedge clk) expr) else $error(msg);
`else
`define BETS_ASSERT(label, expr, msg)
`define BETS_ASSERT_ANY(label, expr, msg)
`endif

`endif

// ----- rtl/bets_pkg.sv -----
`default_nettype none

package bets_pkg;

    localparam int ACTION_W     = 2;
    localparam int INDEX_W      = 10;
    localparam int NODE_FIELD_W = 11;
    localparam int REL_W        = 2;
    localparam int BSTART_W     = 11;

    localparam int TABLE_SIZE_DEF   = 1024;
    localparam int BUCKET_COUNT_DEF = 16;
    localparam int NODE_WIDTH_DEF   = 11;
    localparam int MAX_MATCHES_DEF  = 63;
    localparam int SPAN_DEF         = TABLE_SIZE_DEF / BUCKET_COUNT_DEF;

    typedef enum logic [ACTION_W-1:0] {
        ACT_EDGE_WR = 2'd0,
        ACT_BKT_WR  = 2'd1,
        ACT_QUERY   = 2'd2
    } action_t;

endpackage

`default_nettype wire

// ----- rtl/bets_if.sv -----
`default_nettype none

interface bets_in_if
    import bets_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [ACTION_W-1:0]     action;
    logic [INDEX_W-1:0]      index;
    logic [NODE_FIELD_W-1:0] edge_src;
    logic [NODE_FIELD_W-1:0] edge_dst;
    logic [REL_W-1:0]        edge_rel;
    logic [BSTART_W-1:0]     bucket_start;
    logic [NODE_FIELD_W-1:0] node;
    logic [REL_W-1:0]        rel;
    logic                    father_search;

    modport source (
        output valid, action, index, edge_src, edge_dst, edge_rel, bucket_start,
               node, rel, father_search,
        input  ready
    );
    modport sink (
        input  valid, action, index, edge_src, edge_dst, edge_rel, bucket_start,
               node, rel, father_search,
        output ready
    );
endinterface

interface bets_out_if
    import bets_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [NODE_FIELD_W-1:0] node_out;
    logic                    found;
    logic                    last;
    logic                    truncated;

    modport source (
        output valid, node_out, found, last, truncated,
        input  ready
    );
    modport sink (
        input  valid, node_out, found, last, truncated,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/bets_divider.sv -----
`default_nettype none
`include "bucketed_edge_table_search_defines.svh"

module bets_divider
    import bets_pkg::*;
#(
    parameter int NODE_WIDTH = NODE_WIDTH_DEF,
    parameter int SPAN       = SPAN_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NODE_WIDTH-1:0] dividend,
    output logic                  done,
    output logic [NODE_WIDTH-1:0] quotient
);

    localparam int SHIFT = NODE_WIDTH + $clog2(SPAN);
    localparam int PW    = SHIFT + NODE_WIDTH + 1;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(SPAN) - 64'd1) / 64'(SPAN);
    localparam int QMAX  = ((1 << NODE_WIDTH) - 1) / SPAN;

    logic                  done_reg, done_next;
    logic [NODE_WIDTH-1:0] quo_reg, quo_next;
    logic [PW-1:0]         prod;

    // multiply by the rounded-up reciprocal of SPAN, exact for any NODE_WIDTH-bit dividend
    assign prod = PW'(dividend) * PW'(RECIP);

    always_comb
    begin
        done_next = start;
        quo_next  = start ? prod[SHIFT +: NODE_WIDTH] : quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `BETS_ASSERT(a_div_start_done, start |=> done_reg, "quotient not ready after start")
    `BETS_ASSERT(a_div_no_restart, done_reg |-> !start, "divider restarted while done")
    `BETS_ASSERT(a_div_quo_range, done_reg |-> quotient <= NODE_WIDTH'(QMAX), "quotient out of range")

endmodule

`default_nettype wire

// ----- rtl/bucketed_edge_table_search.sv -----
// channel | dir | fields
// req     | in  | action index edge_src edge_dst edge_rel bucket_start node rel father_search
// rsp     | out | node_out found last truncated
//
// A query finds the node's bucket with a divider, reads its bounds, then scans
// edge entries; the scan is paced by the single read port of the edge memory.
// req.ready is low for the whole query; rsp has an output register, a stalled
// result holds the scan. rst_n is asynchronous and clears control only; both
// tables hold no defined content until written.
`default_nettype none
`include "bucketed_edge_table_search_defines.svh"

module bucketed_edge_table_search
    import bets_pkg::*;
#(
    parameter int TABLE_SIZE   = TABLE_SIZE_DEF,
    parameter int BUCKET_COUNT = BUCKET_COUNT_DEF,
    parameter int NODE_WIDTH   = NODE_WIDTH_DEF,
    parameter int MAX_MATCHES  = MAX_MATCHES_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    bets_in_if.sink    req,
    bets_out_if.source rsp
);

    localparam int SPAN_RAW = TABLE_SIZE / BUCKET_COUNT;
    localparam int SPAN     = (SPAN_RAW == 0) ? 1 : SPAN_RAW;
    localparam int AW       = $clog2(TABLE_SIZE);
    localparam int BW       = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int CW       = ((AW > BSTART_W) ? AW : BSTART_W) + 1;
    localparam int EW       = 2 * NODE_WIDTH + REL_W;
    localparam int MW       = $clog2(MAX_MATCHES + 1);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIV  = 7'b0000010,
        ST_HI   = 7'b0000100,
        ST_LO   = 7'b0001000,
        ST_ST   = 7'b0010000,
        ST_SCAN = 7'b0100000,
        ST_END  = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [NODE_WIDTH-1:0]   node_reg, node_next;
    logic [REL_W-1:0]        rel_reg, rel_next;
    logic                    father_reg, father_next;
    logic [BW-1:0]           bkt_reg, bkt_next;
    logic                    lastb_reg, lastb_next;
    logic [CW-1:0]           bound_reg, bound_next;
    logic [AW-1:0]           addr_reg, addr_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    dv_reg, dv_next;
    logic                    matched_reg, matched_next;
    logic [MW-1:0]           nmatch_reg, nmatch_next;
    logic                    trunc_reg, trunc_next;
    logic                    out_valid_reg, out_valid_next;
    logic [NODE_FIELD_W-1:0] out_node_reg, out_node_next;
    logic                    out_found_reg, out_found_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_trunc_reg, out_trunc_next;

    logic [EW-1:0]       edge_mem [TABLE_SIZE];
    logic [EW-1:0]       edge_rd_reg;
    logic [BSTART_W-1:0] bkt_mem [BUCKET_COUNT];
    logic [BSTART_W-1:0] bkt_rd_reg;

    logic                  accept;
    logic                  out_free;
    logic                  out_load;
    logic                  edge_we, edge_re;
    logic                  bkt_we, bkt_re;
    logic [BW-1:0]         bkt_raddr;
    logic [EW-1:0]         edge_wdata;
    logic [NODE_WIDTH-1:0] node_in;
    logic                  root_query;
    logic                  div_start, div_done;
    logic [NODE_WIDTH-1:0] dividend, div_quo;
    logic                  q_last;
    logic [NODE_WIDTH-1:0] e_src, e_dst;
    logic [REL_W-1:0]      e_rel;
    logic                  hit_src, chit, fhit, want;
    logic                  room;
    logic [CW-1:0]         hi_raw, child_end, father_top, start_val;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;

    assign node_in    = NODE_WIDTH'(req.node);
    assign root_query = req.father_search && (node_in == NODE_WIDTH'(1));
    assign dividend   = (req.father_search && node_in != '0) ? node_in - 1'b1 : node_in;
    assign div_start  = accept && (req.action == ACT_QUERY) && !root_query;

    assign edge_we    = accept && (req.action == ACT_EDGE_WR) && (int'(req.index) < TABLE_SIZE);
    assign bkt_we     = accept && (req.action == ACT_BKT_WR) && (int'(req.index) < BUCKET_COUNT);
    assign edge_wdata = {NODE_WIDTH'(req.edge_src), NODE_WIDTH'(req.edge_dst), req.edge_rel};

    bets_divider #(
        .NODE_WIDTH (NODE_WIDTH),
        .SPAN       (SPAN)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign q_last = int'(div_quo) >= BUCKET_COUNT - 1;

    assign e_src = edge_rd_reg[EW-1 -: NODE_WIDTH];
    assign e_dst = edge_rd_reg[NODE_WIDTH+REL_W-1:REL_W];
    assign e_rel = edge_rd_reg[REL_W-1:0];

    assign hit_src = (e_src == node_reg);
    assign chit    = hit_src && (e_rel == rel_reg);
    assign fhit    = (e_dst == node_reg) && (e_rel == rel_reg);
    assign room    = nmatch_reg < MW'(MAX_MATCHES);
    assign want    = dv_reg && (father_reg ? fhit : (chit && room));

    assign hi_raw     = lastb_reg ? CW'(TABLE_SIZE) : CW'(bkt_rd_reg);
    assign child_end  = (hi_raw > CW'(TABLE_SIZE)) ? CW'(TABLE_SIZE) : hi_raw;
    assign father_top = (hi_raw > CW'(TABLE_SIZE - 1)) ? CW'(TABLE_SIZE - 1) : hi_raw;
    assign start_val  = CW'(bkt_rd_reg);

    always_comb
    begin
        state_next     = state_reg;
        node_next      = node_reg;
        rel_next       = rel_reg;
        father_next    = father_reg;
        bkt_next       = bkt_reg;
        lastb_next     = lastb_reg;
        bound_next     = bound_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        dv_next        = dv_reg;
        matched_next   = matched_reg;
        nmatch_next    = nmatch_reg;
        trunc_next     = trunc_reg;
        out_load       = 1'b0;
        out_node_next  = out_node_reg;
        out_found_next = out_found_reg;
        out_last_next  = out_last_reg;
        out_trunc_next = out_trunc_reg;
        edge_re        = 1'b0;
        bkt_re         = 1'b0;
        bkt_raddr      = bkt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.action == ACT_QUERY)
                begin
                    node_next    = node_in;
                    rel_next     = req.rel;
                    father_next  = req.father_search;
                    matched_next = 1'b0;
                    nmatch_next  = '0;
                    trunc_next   = 1'b0;
                    state_next   = root_query ? ST_END : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    bkt_next   = q_last ? BW'(BUCKET_COUNT - 1) : BW'(div_quo);
                    lastb_next = q_last;
                    state_next = ST_HI;
                end
            end
            ST_HI:
            begin
                bkt_re     = 1'b1;
                bkt_raddr  = lastb_reg ? bkt_reg : BW'(bkt_reg + 1'b1);
                state_next = ST_LO;
            end
            ST_LO:
            begin
                if (father_reg)
                begin
                    addr_next  = AW'(father_top);
                    cnt_next   = CW'(father_top + 1'b1);
                    dv_next    = 1'b0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    bound_next = child_end;
                    bkt_re     = 1'b1;
                    bkt_raddr  = bkt_reg;
                    state_next = ST_ST;
                end
            end
            ST_ST:
            begin
                cnt_next   = (bound_reg > start_val) ? CW'(bound_reg - start_val) : '0;
                addr_next  = AW'(start_val);
                dv_next    = 1'b0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                priority if (dv_reg && !father_reg && matched_reg && !hit_src)
                begin
                    state_next = ST_END;
                end
                else if (want && !out_free)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    if (want)
                    begin
                        out_load       = 1'b1;
                        out_node_next  = NODE_FIELD_W'(father_reg ? e_src : e_dst);
                        out_found_next = 1'b1;
                        out_last_next  = 1'b0;
                        out_trunc_next = 1'b0;
                    end
                    if (want && father_reg)
                    begin
                        state_next = ST_END;
                    end
                    else
                    begin
                        if (dv_reg && !father_reg && chit)
                        begin
                            matched_next = 1'b1;
                            if (room)
                                nmatch_next = MW'(nmatch_reg + 1'b1);
                            else
                                trunc_next = 1'b1;
                        end
                        if (cnt_reg != '0)
                        begin
                            edge_re   = 1'b1;
                            addr_next = father_reg ? AW'(addr_reg - 1'b1) : AW'(addr_reg + 1'b1);
                            cnt_next  = CW'(cnt_reg - 1'b1);
                            dv_next   = 1'b1;
                        end
                        else
                        begin
                            dv_next = 1'b0;
                            if (!dv_reg)
                                state_next = ST_END;
                        end
                    end
                end
            end
            ST_END:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_node_next  = '0;
                    out_found_next = 1'b0;
                    out_last_next  = 1'b1;
                    out_trunc_next = trunc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dv_reg        <= 1'b0;
            matched_reg   <= 1'b0;
            nmatch_reg    <= '0;
            trunc_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            father_reg    <= 1'b0;
            lastb_reg     <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            dv_reg        <= dv_next;
            matched_reg   <= matched_next;
            nmatch_reg    <= nmatch_next;
            trunc_reg     <= trunc_next;
            out_valid_reg <= out_valid_next;
            father_reg    <= father_next;
            lastb_reg     <= lastb_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg      <= node_next;
        rel_reg       <= rel_next;
        bkt_reg       <= bkt_next;
        bound_reg     <= bound_next;
        addr_reg      <= addr_next;
        out_node_reg  <= out_node_next;
        out_found_reg <= out_found_next;
        out_last_reg  <= out_last_next;
        out_trunc_reg <= out_trunc_next;
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[AW'(req.index)] <= edge_wdata;
        if (edge_re)
            edge_rd_reg <= edge_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (bkt_we)
            bkt_mem[BW'(req.index)] <= req.bucket_start;
        if (bkt_re)
            bkt_rd_reg <= bkt_mem[bkt_raddr];
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.node_out  = out_node_reg;
    assign rsp.found     = out_found_reg;
    assign rsp.last      = out_last_reg;
    assign rsp.truncated = out_trunc_reg;

    `BETS_ASSERT(a_scan_cnt_down, (state_reg == ST_SCAN) && $past(state_reg == ST_SCAN) |-> cnt_reg <= $past(cnt_reg), "scan count grew")
    `BETS_ASSERT(a_nmatch_cap, nmatch_reg <= MW'(MAX_MATCHES), "match count above cap")
    `BETS_ASSERT(a_trunc_full, trunc_reg |-> nmatch_reg == MW'(MAX_MATCHES), "truncated before cap")
    `BETS_ASSERT(a_end_to_idle, (state_reg == ST_END) && out_free |=> state_reg == ST_IDLE, "end word did not close query")
    `BETS_ASSERT(a_father_once, (state_reg == ST_SCAN) && father_reg && out_load |=> state_reg == ST_END, "father scan went on after a hit")

endmodule

`default_nettype wire
